>>> hw/rtl/cia_pkg.sv
package cia_pkg;

   localparam int ID_W     = 16;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC       = 3'd0,
      CMD_ALLOC_RSV   = 3'd1,
      CMD_RESERVE     = 3'd2,
      CMD_FREE        = 3'd3,
      CMD_FIND_CID    = 3'd4,
      CMD_FIND_REMOTE = 3'd5,
      CMD_PSM_USED    = 3'd6,
      CMD_COUNT       = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_REMOTE_USED = 3'd1,
      ST_NO_FREE     = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_TAKEN       = 3'd4,
      ST_BAD_PSM     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_DRAIN  = 2'd2,
      S_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_stat_type;

endpackage

>>> hw/rtl/cia_ctrl.sv
module cia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output cia_pkg::ctrl_cmd_type ctrl,
   input  cia_pkg::dp_stat_type  stat
);

   cia_pkg::state_type state_ff;
   cia_pkg::state_type state_in;
   logic               strobe_ff;
   logic               strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cia_pkg::S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.scan   = 1'b0;
      ctrl.finish = 1'b0;
      case (state_ff)
         cia_pkg::S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = cia_pkg::S_SCAN;
            end
         end
         cia_pkg::S_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = cia_pkg::S_DRAIN;
            end
         end
         cia_pkg::S_DRAIN: begin
            state_in = cia_pkg::S_FINISH;
         end
         cia_pkg::S_FINISH: begin
            ctrl.finish = 1'b1;
            strobe_in   = 1'b1;
            state_in    = cia_pkg::S_IDLE;
         end
         default: begin
            state_in = cia_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != cia_pkg::S_IDLE);
   assign rsp_strobe = strobe_ff;

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == cia_pkg::S_FINISH))
      else $error("result strobe without a finishing cycle");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == cia_pkg::S_IDLE) |=> state_ff == cia_pkg::S_SCAN)
      else $error("accepted beat did not start the scan");

   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == cia_pkg::S_DRAIN) |-> $past(stat.scan_last))
      else $error("scan ended before the last slot");

endmodule

>>> hw/rtl/cia_dpath.sv
module cia_dpath #(
   parameter int NUM_IDS  = 64,
   parameter int FIRST_ID = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cia_pkg::ctrl_cmd_type        ctrl,
   output cia_pkg::dp_stat_type         stat,
   input  logic [cia_pkg::CMD_W-1:0]    req_cmd,
   input  logic [cia_pkg::ID_W-1:0]     req_cid,
   input  logic [cia_pkg::ID_W-1:0]     req_psm,
   input  logic [cia_pkg::ID_W-1:0]     req_remote_cid,
   output logic [cia_pkg::STATUS_W-1:0] rsp_status,
   output logic [cia_pkg::ID_W-1:0]     rsp_cid_out,
   output logic [cia_pkg::ID_W-1:0]     rsp_psm_out,
   output logic [cia_pkg::ID_W-1:0]     rsp_remote_cid_out,
   output logic [cia_pkg::COUNT_W-1:0]  rsp_channel_count
);

   localparam int IDX_W     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam int CNT_W     = $clog2(NUM_IDS + 1);
   localparam int EXT_W     = cia_pkg::ID_W + 1;
   localparam int LAST_SLOT = 65535 - FIRST_ID;
   localparam int ENT_W     = 2 * cia_pkg::ID_W;

   // Request beat, held for the whole command.
   cia_pkg::cmd_type          cmd_ff;
   logic [cia_pkg::ID_W-1:0]  psm_ff;
   logic [cia_pkg::ID_W-1:0]  rem_ff;
   logic [IDX_W-1:0]          slot_ff;
   logic                      win_ff;

   // Table state.
   logic [NUM_IDS-1:0]        in_use_ff;
   logic [NUM_IDS-1:0]        valid_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [ENT_W-1:0]          mem [NUM_IDS];

   // Scan pipeline.
   logic [IDX_W-1:0]          addr_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      rd_vld_ff;
   logic [ENT_W-1:0]          rd_data_ff;
   logic [cia_pkg::ID_W-1:0]  rd_psm;
   logic [cia_pkg::ID_W-1:0]  rd_rem;

   // Scan results.
   logic                      rem_found_ff;
   logic                      free_found_ff;
   logic [IDX_W-1:0]          free_idx_ff;
   logic                      tgt_found_ff;
   logic [IDX_W-1:0]          tgt_idx_ff;
   logic [cia_pkg::ID_W-1:0]  tgt_psm_ff;
   logic [cia_pkg::ID_W-1:0]  tgt_rem_ff;

   // Response registers.
   cia_pkg::status_type       rsp_status_ff;
   logic [cia_pkg::ID_W-1:0]  rsp_cid_ff;
   logic [cia_pkg::ID_W-1:0]  rsp_psm_ff;
   logic [cia_pkg::ID_W-1:0]  rsp_rem_ff;

   logic [EXT_W-1:0]          cid_ext;
   logic [EXT_W-1:0]          cid_off;
   logic                      cid_win;
   logic                      match_rem;
   logic                      match_psm;
   logic                      slot_free;
   logic                      tgt_sel;
   logic                      psm_ok;

   cia_pkg::status_type       st_c;
   logic                      hit_c;
   logic [IDX_W-1:0]          hit_idx_c;
   logic [cia_pkg::ID_W-1:0]  out_psm_c;
   logic [cia_pkg::ID_W-1:0]  out_rem_c;
   logic                      bind_c;
   logic [IDX_W-1:0]          bind_idx_c;
   logic                      set_use_c;
   logic                      clr_use_c;
   logic                      clr_valid_c;

   assign cid_ext = {1'b0, req_cid};
   assign cid_off = cid_ext - EXT_W'(FIRST_ID);
   assign cid_win = (cid_ext >= EXT_W'(FIRST_ID)) && (cid_off < EXT_W'(NUM_IDS));

   assign rd_psm = rd_data_ff[ENT_W-1:cia_pkg::ID_W];
   assign rd_rem = rd_data_ff[cia_pkg::ID_W-1:0];

   assign match_rem = valid_ff[rd_idx_ff] && (rd_rem == rem_ff);
   assign match_psm = valid_ff[rd_idx_ff] && (rd_psm == psm_ff);
   assign slot_free = !in_use_ff[rd_idx_ff] && (EXT_W'(rd_idx_ff) <= EXT_W'(LAST_SLOT));

   always_comb begin
      case (cmd_ff)
         cia_pkg::CMD_FIND_REMOTE: tgt_sel = match_rem;
         cia_pkg::CMD_PSM_USED:    tgt_sel = match_psm;
         cia_pkg::CMD_FREE,
         cia_pkg::CMD_FIND_CID:    tgt_sel = (rd_idx_ff == slot_ff);
         default:                  tgt_sel = 1'b0;
      endcase
   end

   assign stat.scan_last = (addr_ff == IDX_W'(NUM_IDS - 1));

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff  <= cia_pkg::cmd_type'(req_cmd);
         psm_ff  <= req_psm;
         rem_ff  <= req_remote_cid;
         slot_ff <= cid_off[IDX_W-1:0];
         win_ff  <= cid_win;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish && bind_c) begin
         mem[bind_idx_c] <= {psm_ff, rem_ff};
      end
      if (ctrl.scan) begin
         rd_data_ff <= mem[addr_ff];
         rd_idx_ff  <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rem_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         tgt_found_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.scan;
         if (ctrl.load) begin
            addr_ff       <= '0;
            rem_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            tgt_found_ff  <= 1'b0;
         end else begin
            if (ctrl.scan) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (match_rem) begin
                  rem_found_ff <= 1'b1;
               end
               if (slot_free && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
               if (tgt_sel && !tgt_found_ff) begin
                  tgt_found_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff && slot_free && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (rd_vld_ff && tgt_sel && !tgt_found_ff) begin
         tgt_idx_ff <= rd_idx_ff;
         tgt_psm_ff <= rd_psm;
         tgt_rem_ff <= rd_rem;
      end
   end

   assign psm_ok = psm_ff[0] && !psm_ff[8];

   always_comb begin
      st_c        = cia_pkg::ST_OK;
      hit_c       = 1'b0;
      hit_idx_c   = tgt_idx_ff;
      out_psm_c   = '0;
      out_rem_c   = '0;
      bind_c      = 1'b0;
      bind_idx_c  = free_idx_ff;
      set_use_c   = 1'b0;
      clr_use_c   = 1'b0;
      clr_valid_c = 1'b0;
      case (cmd_ff)
         cia_pkg::CMD_ALLOC: begin
            if (!psm_ok) begin
               st_c = cia_pkg::ST_BAD_PSM;
            end else if (rem_found_ff) begin
               st_c = cia_pkg::ST_REMOTE_USED;
            end else if (!free_found_ff) begin
               st_c = cia_pkg::ST_NO_FREE;
            end else if (valid_ff[free_idx_ff]) begin
               st_c = cia_pkg::ST_TAKEN;
            end else begin
               bind_c    = 1'b1;
               set_use_c = 1'b1;
               hit_c     = 1'b1;
               hit_idx_c = free_idx_ff;
               out_psm_c = psm_ff;
               out_rem_c = rem_ff;
            end
         end
         cia_pkg::CMD_ALLOC_RSV: begin
            bind_idx_c = slot_ff;
            if (!psm_ok) begin
               st_c = cia_pkg::ST_BAD_PSM;
            end else if (rem_found_ff) begin
               st_c = cia_pkg::ST_REMOTE_USED;
            end else if (!win_ff || valid_ff[slot_ff]) begin
               st_c = cia_pkg::ST_TAKEN;
            end else begin
               bind_c    = 1'b1;
               hit_c     = 1'b1;
               hit_idx_c = slot_ff;
               out_psm_c = psm_ff;
               out_rem_c = rem_ff;
            end
         end
         cia_pkg::CMD_RESERVE: begin
            if (!free_found_ff) begin
               st_c = cia_pkg::ST_NO_FREE;
            end else begin
               set_use_c = 1'b1;
               hit_c     = 1'b1;
               hit_idx_c = free_idx_ff;
            end
         end
         cia_pkg::CMD_FREE: begin
            clr_use_c = win_ff;
            if (!win_ff || !valid_ff[slot_ff]) begin
               st_c = cia_pkg::ST_NOT_FOUND;
            end else begin
               clr_valid_c = 1'b1;
               hit_c       = 1'b1;
               hit_idx_c   = slot_ff;
               out_psm_c   = tgt_psm_ff;
               out_rem_c   = tgt_rem_ff;
            end
         end
         cia_pkg::CMD_FIND_CID: begin
            if (!win_ff || !valid_ff[slot_ff]) begin
               st_c = cia_pkg::ST_NOT_FOUND;
            end else begin
               hit_c     = 1'b1;
               hit_idx_c = slot_ff;
               out_psm_c = tgt_psm_ff;
               out_rem_c = tgt_rem_ff;
            end
         end
         cia_pkg::CMD_FIND_REMOTE,
         cia_pkg::CMD_PSM_USED: begin
            if (!tgt_found_ff) begin
               st_c = cia_pkg::ST_NOT_FOUND;
            end else begin
               hit_c     = 1'b1;
               out_psm_c = tgt_psm_ff;
               out_rem_c = tgt_rem_ff;
            end
         end
         default: begin
            st_c = cia_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (bind_c) begin
         count_in = count_ff + 1'b1;
      end else if (clr_valid_c) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         valid_ff  <= '0;
         count_ff  <= '0;
      end else if (ctrl.finish) begin
         count_ff <= count_in;
         if (set_use_c) begin
            in_use_ff[hit_idx_c] <= 1'b1;
         end
         if (clr_use_c) begin
            in_use_ff[slot_ff] <= 1'b0;
         end
         if (bind_c) begin
            valid_ff[bind_idx_c] <= 1'b1;
         end
         if (clr_valid_c) begin
            valid_ff[slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_status_ff <= st_c;
         rsp_cid_ff    <= hit_c ? cia_pkg::ID_W'(EXT_W'(FIRST_ID) + EXT_W'(hit_idx_c)) : '0;
         rsp_psm_ff    <= out_psm_c;
         rsp_rem_ff    <= out_rem_c;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_cid_out        = rsp_cid_ff;
   assign rsp_psm_out        = rsp_psm_ff;
   assign rsp_remote_cid_out = rsp_rem_ff;
   assign rsp_channel_count  = cia_pkg::COUNT_W'(32'(count_ff));

   a_count_matches_entries: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("live count disagrees with the entry table");

   a_bind_to_empty_slot: assert property (@(posedge clock) disable iff (reset)
      (ctrl.finish && bind_c) |-> !valid_ff[bind_idx_c])
      else $error("binding over a live entry");

   a_free_live_slot: assert property (@(posedge clock) disable iff (reset)
      (ctrl.finish && clr_valid_c) |-> (win_ff && valid_ff[slot_ff]))
      else $error("releasing an entry that is not live");

endmodule

>>> hw/rtl/channel_id_allocator.sv
// Channel identifier allocator.
// Command port: a beat is taken at a rising edge where start is high and busy
// is low; req_cmd selects allocate, allocate reserved, reserve, free, find by
// local id, find by remote id, protocol number query or count, with req_cid,
// req_psm and req_remote_cid as operands.
// Result port: every command gives one result, shown for exactly one cycle
// with rsp_strobe high; the receiver cannot stall it.
// Each command scans all NUM_IDS slots of the entry memory, one slot per
// cycle through its single read port, then passes through a drain state for
// the last read and a finishing state for the table update. The strobe is
// registered from the finishing state, and busy drops in that same cycle, so
// a new command can be taken while the result is shown.
// Reset clears the in-use and entry-valid bits and the live count at once;
// the protocol number and remote id memory is only read for live entries and
// needs no clearing, so the block is ready in the first cycle after reset.
module channel_id_allocator #(
   parameter int NUM_IDS  = 64,
   parameter int FIRST_ID = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cia_pkg::CMD_W-1:0]    req_cmd,
   input  logic [cia_pkg::ID_W-1:0]     req_cid,
   input  logic [cia_pkg::ID_W-1:0]     req_psm,
   input  logic [cia_pkg::ID_W-1:0]     req_remote_cid,
   output logic                         rsp_strobe,
   output logic [cia_pkg::STATUS_W-1:0] rsp_status,
   output logic [cia_pkg::ID_W-1:0]     rsp_cid_out,
   output logic [cia_pkg::ID_W-1:0]     rsp_psm_out,
   output logic [cia_pkg::ID_W-1:0]     rsp_remote_cid_out,
   output logic [cia_pkg::COUNT_W-1:0]  rsp_channel_count
);

   cia_pkg::ctrl_cmd_type ctrl;
   cia_pkg::dp_stat_type  stat;

   cia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   cia_dpath #(
      .NUM_IDS  (NUM_IDS),
      .FIRST_ID (FIRST_ID)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_cmd            (req_cmd),
      .req_cid            (req_cid),
      .req_psm            (req_psm),
      .req_remote_cid     (req_remote_cid),
      .rsp_status         (rsp_status),
      .rsp_cid_out        (rsp_cid_out),
      .rsp_psm_out        (rsp_psm_out),
      .rsp_remote_cid_out (rsp_remote_cid_out),
      .rsp_channel_count  (rsp_channel_count)
   );

endmodule

>>> tb/sv/tb_channel_id_allocator.sv
module tb_channel_id_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_IDS      = 64;
   localparam int FIRST_ID     = 64;
   localparam int RANDOM_CMDS  = 930;
   localparam int LIMIT_CYCLES = 400000;
   localparam int MAX_PRINTS   = 100;

   typedef struct {
      cia_pkg::cmd_type         cmd;
      logic [cia_pkg::ID_W-1:0] cid;
      logic [cia_pkg::ID_W-1:0] psm;
      logic [cia_pkg::ID_W-1:0] remote;
      int                       gap_pct;
      bit                       drain;
   } cid_request_type;

   typedef struct {
      cia_pkg::status_type         status;
      logic [cia_pkg::ID_W-1:0]    cid;
      logic [cia_pkg::ID_W-1:0]    psm;
      logic [cia_pkg::ID_W-1:0]    remote;
      logic [cia_pkg::COUNT_W-1:0] count;
   } cid_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [cia_pkg::CMD_W-1:0] req_cmd = '0;
   logic [cia_pkg::ID_W-1:0] req_cid = '0;
   logic [cia_pkg::ID_W-1:0] req_psm = '0;
   logic [cia_pkg::ID_W-1:0] req_remote_cid = '0;
   logic rsp_strobe;
   logic [cia_pkg::STATUS_W-1:0] rsp_status;
   logic [cia_pkg::ID_W-1:0] rsp_cid_out;
   logic [cia_pkg::ID_W-1:0] rsp_psm_out;
   logic [cia_pkg::ID_W-1:0] rsp_remote_cid_out;
   logic [cia_pkg::COUNT_W-1:0] rsp_channel_count;

   cid_request_type pending_cmds[$];
   cid_response_type expected_rsps[$];
   int open_cmds = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   bit id_taken[NUM_IDS];
   bit slot_live[NUM_IDS];
   logic [cia_pkg::ID_W-1:0] slot_psm[NUM_IDS];
   logic [cia_pkg::ID_W-1:0] slot_remote[NUM_IDS];
   int live_entries = 0;

   channel_id_allocator #(
      .NUM_IDS(NUM_IDS),
      .FIRST_ID(FIRST_ID)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_cid(req_cid),
      .req_psm(req_psm),
      .req_remote_cid(req_remote_cid),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_cid_out(rsp_cid_out),
      .rsp_psm_out(rsp_psm_out),
      .rsp_remote_cid_out(rsp_remote_cid_out),
      .rsp_channel_count(rsp_channel_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTS) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   function automatic int window_slot(logic [cia_pkg::ID_W-1:0] id);
      int v;
      v = id;
      if (v < FIRST_ID || v - FIRST_ID >= NUM_IDS) return -1;
      return v - FIRST_ID;
   endfunction

   function automatic int lowest_unused_slot();
      for (int i = 0; i < NUM_IDS; i++) begin
         if (FIRST_ID + i > 16'hFFFF) return -1;
         if (!id_taken[i]) return i;
      end
      return -1;
   endfunction

   function automatic int slot_with_remote(logic [cia_pkg::ID_W-1:0] remote);
      for (int i = 0; i < NUM_IDS; i++) begin
         if (slot_live[i] && slot_remote[i] == remote) return i;
      end
      return -1;
   endfunction

   function automatic cid_response_type apply_command(cia_pkg::cmd_type cmd,
                                                      logic [cia_pkg::ID_W-1:0] cid,
                                                      logic [cia_pkg::ID_W-1:0] psm,
                                                      logic [cia_pkg::ID_W-1:0] remote);
      cid_response_type r;
      int s;
      int hit;
      bit with_entry;
      r.status = cia_pkg::ST_OK;
      hit = -1;
      with_entry = 1'b1;
      case (cmd)
         cia_pkg::CMD_ALLOC, cia_pkg::CMD_ALLOC_RSV: begin
            if ((psm & 16'h0101) != 16'h0001) begin
               r.status = cia_pkg::ST_BAD_PSM;
            end else if (slot_with_remote(remote) >= 0) begin
               r.status = cia_pkg::ST_REMOTE_USED;
            end else begin
               if (cmd == cia_pkg::CMD_ALLOC) begin
                  s = lowest_unused_slot();
                  if (s < 0) begin
                     r.status = cia_pkg::ST_NO_FREE;
                  end else if (slot_live[s]) begin
                     r.status = cia_pkg::ST_TAKEN;
                  end else begin
                     id_taken[s] = 1'b1;
                     hit = s;
                  end
               end else begin
                  s = window_slot(cid);
                  if (s < 0 || slot_live[s]) r.status = cia_pkg::ST_TAKEN;
                  else hit = s;
               end
               if (hit >= 0) begin
                  slot_live[hit] = 1'b1;
                  slot_psm[hit] = psm;
                  slot_remote[hit] = remote;
                  live_entries++;
               end
            end
         end
         cia_pkg::CMD_RESERVE: begin
            s = lowest_unused_slot();
            if (s < 0) begin
               r.status = cia_pkg::ST_NO_FREE;
            end else begin
               id_taken[s] = 1'b1;
               hit = s;
               with_entry = 1'b0;
            end
         end
         cia_pkg::CMD_FREE: begin
            s = window_slot(cid);
            if (s >= 0) id_taken[s] = 1'b0;
            if (s < 0 || !slot_live[s]) begin
               r.status = cia_pkg::ST_NOT_FOUND;
            end else begin
               slot_live[s] = 1'b0;
               live_entries--;
               hit = s;
            end
         end
         cia_pkg::CMD_FIND_CID: begin
            s = window_slot(cid);
            if (s < 0 || !slot_live[s]) r.status = cia_pkg::ST_NOT_FOUND;
            else hit = s;
         end
         cia_pkg::CMD_FIND_REMOTE: begin
            s = slot_with_remote(remote);
            if (s < 0) r.status = cia_pkg::ST_NOT_FOUND;
            else hit = s;
         end
         cia_pkg::CMD_PSM_USED: begin
            for (int i = NUM_IDS - 1; i >= 0; i--) begin
               if (slot_live[i] && slot_psm[i] == psm) hit = i;
            end
            if (hit < 0) r.status = cia_pkg::ST_NOT_FOUND;
         end
         default: begin
         end
      endcase
      r.cid = (hit >= 0) ? cia_pkg::ID_W'(FIRST_ID + hit) : '0;
      r.psm = (hit >= 0 && with_entry) ? slot_psm[hit] : '0;
      r.remote = (hit >= 0 && with_entry) ? slot_remote[hit] : '0;
      r.count = cia_pkg::COUNT_W'(live_entries);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_cmds.size() > 0 &&
             $urandom_range(99) >= pending_cmds[0].gap_pct &&
             !(pending_cmds[0].drain && (start || open_cmds != 0))) begin
            req_cmd <= pending_cmds[0].cmd;
            req_cid <= pending_cmds[0].cid;
            req_psm <= pending_cmds[0].psm;
            req_remote_cid <= pending_cmds[0].remote;
            start <= 1'b1;
            void'(pending_cmds.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      cid_response_type want;
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            flag_mismatch("result strobe is unknown");
         end else if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               flag_mismatch("result beat with no command outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_cid_out !== want.cid)
                  flag_mismatch($sformatf("cid_out %0d, want %0d", rsp_cid_out, want.cid));
               if (rsp_psm_out !== want.psm)
                  flag_mismatch($sformatf("psm_out %h, want %h", rsp_psm_out, want.psm));
               if (rsp_remote_cid_out !== want.remote)
                  flag_mismatch($sformatf("remote_cid_out %h, want %h",
                                          rsp_remote_cid_out, want.remote));
               if (rsp_channel_count !== want.count)
                  flag_mismatch($sformatf("channel_count %0d, want %0d",
                                          rsp_channel_count, want.count));
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(apply_command(cia_pkg::cmd_type'(req_cmd), req_cid,
                                                  req_psm, req_remote_cid));
         end
         open_cmds <= expected_rsps.size();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_cmd(input cia_pkg::cmd_type cmd,
                            input logic [cia_pkg::ID_W-1:0] cid,
                            input logic [cia_pkg::ID_W-1:0] psm,
                            input logic [cia_pkg::ID_W-1:0] remote);
      cid_request_type it;
      it.cmd = cmd;
      it.cid = cid;
      it.psm = psm;
      it.remote = remote;
      it.gap_pct = 0;
      it.drain = 1'b0;
      pending_cmds.push_back(it);
   endtask

   initial begin
      cid_request_type it;
      int gap_by_phase[4];
      int roll;
      bit grow;
      gap_by_phase = '{0, 56, 0, 23};

      queue_cmd(cia_pkg::CMD_COUNT, 16'd0, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FREE, 16'd64, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FIND_CID, 16'd0, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FIND_REMOTE, 16'd0, 16'd0, 16'hFFFF);
      queue_cmd(cia_pkg::CMD_PSM_USED, 16'd0, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'd0, 16'h0000, 16'h0007);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'd0, 16'h0101, 16'h0007);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'hFFFF, 16'h0001, 16'h0000);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'd0, 16'hFEFF, 16'hFFFF);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'd0, 16'h0003, 16'hFFFF);
      queue_cmd(cia_pkg::CMD_ALLOC_RSV, 16'd66, 16'h0007, 16'h1234);
      queue_cmd(cia_pkg::CMD_ALLOC, 16'd0, 16'h0005, 16'h2222);
      queue_cmd(cia_pkg::CMD_ALLOC_RSV, 16'd63, 16'h0009, 16'h3333);
      queue_cmd(cia_pkg::CMD_ALLOC_RSV, 16'd127, 16'h0009, 16'h5555);
      queue_cmd(cia_pkg::CMD_ALLOC_RSV, 16'd128, 16'h000B, 16'h6666);
      queue_cmd(cia_pkg::CMD_ALLOC_RSV, 16'hFFFF, 16'h000B, 16'h7777);
      queue_cmd(cia_pkg::CMD_RESERVE, 16'd0, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FIND_CID, 16'd66, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FIND_REMOTE, 16'd0, 16'd0, 16'h1234);
      queue_cmd(cia_pkg::CMD_PSM_USED, 16'd0, 16'hFEFF, 16'd0);
      queue_cmd(cia_pkg::CMD_FREE, 16'd65, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FREE, 16'd65, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FREE, 16'd0, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_FREE, 16'd66, 16'd0, 16'd0);
      queue_cmd(cia_pkg::CMD_COUNT, 16'd0, 16'd0, 16'd0);

      // Commands alternate between stretches that mostly fill the window and
      // stretches that mostly release it, so the full window is reached often.
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         grow = ((i / 70) % 2) == 0;
         roll = $urandom_range(99);
         if (grow) begin
            if (roll < 40) it.cmd = cia_pkg::CMD_ALLOC;
            else if (roll < 55) it.cmd = cia_pkg::CMD_ALLOC_RSV;
            else if (roll < 70) it.cmd = cia_pkg::CMD_RESERVE;
            else if (roll < 78) it.cmd = cia_pkg::CMD_FREE;
            else it.cmd = cia_pkg::cmd_type'($urandom_range(7, 4));
         end else begin
            if (roll < 10) it.cmd = cia_pkg::CMD_ALLOC;
            else if (roll < 15) it.cmd = cia_pkg::CMD_ALLOC_RSV;
            else if (roll < 20) it.cmd = cia_pkg::CMD_RESERVE;
            else if (roll < 65) it.cmd = cia_pkg::CMD_FREE;
            else it.cmd = cia_pkg::cmd_type'($urandom_range(7, 4));
         end
         if ($urandom_range(99) < 85)
            it.cid = cia_pkg::ID_W'($urandom_range(FIRST_ID + NUM_IDS - 1, FIRST_ID));
         else
            it.cid = cia_pkg::ID_W'($urandom);
         roll = $urandom_range(99);
         if (roll < 80) it.psm = cia_pkg::ID_W'(($urandom_range(7) << 1) | 1);
         else if (roll < 90) it.psm = (cia_pkg::ID_W'($urandom) & 16'hFEFF) | 16'h0001;
         else it.psm = cia_pkg::ID_W'($urandom);
         if ($urandom_range(99) < 80) it.remote = cia_pkg::ID_W'($urandom_range(150));
         else it.remote = cia_pkg::ID_W'($urandom);
         it.gap_pct = gap_by_phase[(i / 120) % 4];
         it.drain = (i % 250) == 0;
         pending_cmds.push_back(it);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_cmds.size() != 0 || start || open_cmds != 0) @(negedge clock);
      repeat (NUM_IDS + 10) @(posedge clock);
      if (expected_rsps.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cia_pkg.sv
hw/rtl/cia_ctrl.sv
hw/rtl/cia_dpath.sv
hw/rtl/channel_id_allocator.sv
tb/sv/tb_channel_id_allocator.sv
